// ----- rtl/pbcr_pkg.sv -----
package pbcr_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS);
    localparam int ADDR_W      = 32;
    localparam int OUT_SLOT_W  = 4;
    localparam int ACT_W       = 2;

    // Request kinds
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot;
        logic                  hit;
        logic                  write_back;
        t_addr                 old_page;
        logic                  last;
    } t_result;

endpackage

// ----- rtl/pbcr_tag_ram.sv -----
module pbcr_tag_ram
    import pbcr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  logic  i_we,
    input  t_slot i_addr,
    input  t_addr i_wdata,
    output t_addr o_rdata
);

    t_addr r_mem [SLOTS];
    t_addr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pbcr_ctrl.sv -----
module pbcr_ctrl
    import pbcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic [ACT_W-1:0] i_action,
    input  t_addr            i_page_addr,
    input  logic             i_out_free,
    output logic             o_res_valid,
    output t_result          o_res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_HIT,
        ST_SWEEP,
        ST_VRD,
        ST_FILL,
        ST_FLUSH,
        ST_FRD
    } t_state;

    t_state r_state, n_state;
    t_slot  r_idx, n_idx;
    t_slot  r_n, n_n;
    logic [1:0] r_pass, n_pass;
    logic [RES_CNT_W-1:0] r_fcnt, n_fcnt;
    t_addr  r_addr, n_addr;
    logic   r_write, n_write;
    logic   r_wb, n_wb;
    t_addr  r_old, n_old;
    t_slot  r_hand, n_hand;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [SLOTS-1:0] r_use, n_use;
    logic [SLOTS-1:0] r_mod, n_mod;
    logic [SLOTS-1:0] r_dirty, n_dirty;

    logic   ram_en, ram_we;
    t_slot  ram_addr;
    t_addr  ram_rdata;
    logic   accept;
    logic   more_dirty;

    function automatic t_slot lowest_set(input logic [SLOTS-1:0] v);
        t_slot idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) idx = SLOT_W'(i);
        end
        return idx;
    endfunction

    function automatic t_slot wrap_inc(input t_slot s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    pbcr_tag_ram u_tag_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign more_dirty  = |(r_dirty & ~(SLOTS'(1) << r_idx));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_n      = r_n;
        n_pass   = r_pass;
        n_fcnt   = r_fcnt;
        n_addr   = r_addr;
        n_write  = r_write;
        n_wb     = r_wb;
        n_old    = r_old;
        n_hand   = r_hand;
        n_valid  = r_valid;
        n_use    = r_use;
        n_mod    = r_mod;
        n_dirty  = r_dirty;
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_idx;
        o_res_valid = 1'b0;
        o_res    = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_addr  = i_page_addr;
                    n_write = (i_action == ACT_WRITE);
                    n_idx   = '0;
                    n_fcnt  = '0;
                    case (i_action)
                        ACT_READ, ACT_WRITE: begin
                            // Start the tag scan at slot zero
                            ram_en   = 1'b1;
                            ram_addr = '0;
                            n_state  = ST_LOOK;
                        end
                        ACT_FLUSH: n_state = ST_FLUSH;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end

            ST_LOOK: begin
                if (r_valid[r_idx] && ram_rdata == r_addr) begin
                    n_state = ST_HIT;
                end else if (r_idx == SLOT_W'(SLOTS - 1)) begin
                    n_wb  = 1'b0;
                    n_old = '0;
                    if (!(&r_valid)) begin
                        n_idx   = lowest_set(~r_valid);
                        n_state = ST_FILL;
                    end else begin
                        n_idx   = wrap_inc(r_hand);
                        n_n     = '0;
                        n_pass  = '0;
                        n_state = ST_SWEEP;
                    end
                end else begin
                    ram_en   = 1'b1;
                    ram_addr = r_idx + 1'b1;
                    n_idx    = r_idx + 1'b1;
                end
            end

            ST_HIT: begin
                if (i_out_free) begin
                    o_res_valid    = 1'b1;
                    o_res.slot     = OUT_SLOT_W'(r_idx);
                    o_res.hit      = 1'b1;
                    o_res.last     = 1'b1;
                    n_use[r_idx]   = 1'b1;
                    if (r_write) begin
                        n_mod[r_idx]   = 1'b1;
                        n_dirty[r_idx] = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end

            ST_SWEEP: begin
                if (!r_use[r_idx] && (r_mod[r_idx] == r_pass[0])) begin
                    if (r_dirty[r_idx]) begin
                        ram_en  = 1'b1;
                        n_state = ST_VRD;
                    end else begin
                        n_state = ST_FILL;
                    end
                end else begin
                    if (r_pass[0]) n_use[r_idx] = 1'b0;
                    if (r_n == SLOT_W'(SLOTS - 1)) begin
                        n_n    = '0;
                        n_idx  = wrap_inc(r_hand);
                        n_pass = r_pass + 1'b1;
                        if (r_pass == 2'd3) n_state = ST_FILL;
                    end else begin
                        n_n   = r_n + 1'b1;
                        n_idx = wrap_inc(r_idx);
                    end
                end
            end

            ST_VRD: begin
                n_wb    = 1'b1;
                n_old   = ram_rdata;
                n_state = ST_FILL;
            end

            ST_FILL: begin
                if (i_out_free) begin
                    ram_en           = 1'b1;
                    ram_we           = 1'b1;
                    n_valid[r_idx]   = 1'b1;
                    n_use[r_idx]     = 1'b1;
                    n_mod[r_idx]     = r_write;
                    n_dirty[r_idx]   = r_write;
                    n_hand           = r_idx;
                    o_res_valid      = 1'b1;
                    o_res.slot       = OUT_SLOT_W'(r_idx);
                    o_res.write_back = r_wb;
                    o_res.old_page   = r_old;
                    o_res.last       = 1'b1;
                    n_state          = ST_IDLE;
                end
            end

            ST_FLUSH: begin
                if (r_dirty == '0) begin
                    // Nothing dirty: one empty result
                    if (i_out_free) begin
                        o_res_valid = 1'b1;
                        o_res.last  = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_idx    = lowest_set(r_dirty);
                    ram_en   = 1'b1;
                    ram_addr = lowest_set(r_dirty);
                    n_state  = ST_FRD;
                end
            end

            ST_FRD: begin
                if (i_out_free) begin
                    o_res_valid      = 1'b1;
                    o_res.slot       = OUT_SLOT_W'(r_idx);
                    o_res.write_back = 1'b1;
                    o_res.old_page   = ram_rdata;
                    o_res.last       = !more_dirty ||
                                       (r_fcnt == RES_CNT_W'(MAX_RESULTS - 1));
                    n_valid[r_idx]   = 1'b0;
                    n_use[r_idx]     = 1'b0;
                    n_mod[r_idx]     = 1'b0;
                    n_dirty[r_idx]   = 1'b0;
                    n_fcnt           = r_fcnt + 1'b1;
                    n_state          = o_res.last ? ST_IDLE : ST_FLUSH;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_pass  <= n_pass;
        r_fcnt  <= n_fcnt;
        r_addr  <= n_addr;
        r_write <= n_write;
        r_wb    <= n_wb;
        r_old   <= n_old;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hand  <= '0;
            r_valid <= '0;
            r_use   <= '0;
            r_mod   <= '0;
            r_dirty <= '0;
        end else begin
            r_state <= n_state;
            r_hand  <= n_hand;
            r_valid <= n_valid;
            r_use   <= n_use;
            r_mod   <= n_mod;
            r_dirty <= n_dirty;
        end
    end

endmodule

// ----- rtl/page_buffer_clock_replacement_core.sv -----
// Read/write: one tag slot compared per cycle; a hit is handed to the output register,
// a miss that finds a free slot fills the lowest one once the scan is through.
// Full buffer: a sweep picks the victim; a dirty victim's tag is read for the write-back.
// Flush: a write-back per dirty slot, else one empty result; output stalls delay them.
// One request at a time: the next is taken the cycle after its last result is registered.
// Sync active-low reset clears the slot bits and the hand; tag RAM contents stay undefined.
module page_buffer_clock_replacement_core
    import pbcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] page_addr
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] slot, [35:4] old_page, [39:36] zero
    output logic [1:0]  m_axis_tuser,   // [0] hit, [1] write_back
    output logic        m_axis_tlast
);

    logic    res_valid;
    t_result res;
    logic    out_free;
    logic    r_out_valid;
    t_result r_out;

    // Output register frees when empty or drained this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    pbcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_page_addr (s_axis_tdata),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Hold the result until the downstream side takes the transaction
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out.old_page, r_out.slot};
    assign m_axis_tuser  = {r_out.write_back, r_out.hit};
    assign m_axis_tlast  = r_out.last;

`ifndef NO_ASSERTIONS
    // A request is worked on alone: no second transaction right after one
    // (the unused action code is dropped on the spot and keeps the input open)
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready &&
         (s_axis_tuser == ACT_READ || s_axis_tuser == ACT_WRITE ||
          s_axis_tuser == ACT_FLUSH)) |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    // Hits never evict
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit reported with write back");

    // Old page is zero unless a write back is reported
    a_old_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[35:4] == '0))
        else $error("old page without write back");

    // A new result is only loaded when the register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> out_free)
        else $error("result overwritten before transfer");
`endif

endmodule

// ----- tb/sv/page_buffer_clock_replacement_core_test.sv -----
`timescale 1ns / 1ps

module page_buffer_clock_replacement_core_test;
    import pbcr_pkg::*;

    // Action code the block accepts but ignores: no state change, no result.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 180;
    localparam int HOLD_OFF_CYCLES = 300;
    // Longest quiet stretch of a correct run: the receiver hold-off, plus a full sweep
    // and a full flush behind it, plus the slowest stall pattern. Take it several times over.
    localparam int STALL_LIMIT     = 3000;
    // Cycles to let pass once nothing is expected: a worst-case miss with a full sweep.
    localparam int DRAIN_CYCLES    = 3 + 5 * SLOTS + 40;

    // Tag bookkeeping for a 16-slot fully associative buffer with second-chance
    // replacement. Every accepted request is turned into the result transactions
    // it must cause; every result transaction is checked against the oldest one.
    class page_tag_scoreboard;
        t_addr       tags[SLOTS];
        bit          vld[SLOTS];
        bit          referenced[SLOTS];
        bit          modified[SLOTS];
        bit          dirty[SLOTS];
        int unsigned hand;
        t_result     awaited[$];
        int          errors;
        int          n_requests;
        int          n_hits;
        int          n_sweeps;
        int          n_write_backs;
        int          n_flushes;
        int          n_results;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                tags[i]       = '0;
                vld[i]        = 1'b0;
                referenced[i] = 1'b0;
                modified[i]   = 1'b0;
                dirty[i]      = 1'b0;
            end
            hand = 0;
        endfunction

        function t_result make_result(int unsigned slot, bit hit, bit wb, t_addr old, bit last);
            t_result r;
            r.slot       = slot[OUT_SLOT_W-1:0];
            r.hit        = hit;
            r.write_back = wb;
            r.old_page   = old;
            r.last       = last;
            return r;
        endfunction

        // Enhanced second chance: look for unused clean slots, then unused modified
        // ones while stripping use bits; two rounds always end on a victim.
        function int unsigned choose_victim();
            int unsigned idx;
            for (int round = 0; round < 2; round++) begin
                idx = hand;
                for (int n = 0; n < SLOTS; n++) begin
                    idx = (idx + 1) % SLOTS;
                    if (!referenced[idx] && !modified[idx])
                        return idx;
                end
                idx = hand;
                for (int n = 0; n < SLOTS; n++) begin
                    idx = (idx + 1) % SLOTS;
                    if (!referenced[idx] && modified[idx])
                        return idx;
                    referenced[idx] = 1'b0;
                end
            end
            return (hand + 1) % SLOTS;
        endfunction

        function void note_request(logic [ACT_W-1:0] action, t_addr addr);
            int unsigned slot;
            int          flushed;
            bit          found;
            bit          wb;
            t_addr       old;
            found   = 1'b0;
            flushed = 0;
            slot    = SLOTS;
            wb      = 1'b0;
            old     = '0;
            if (action == ACT_UNUSED)
                return;
            n_requests++;
            if (action == ACT_FLUSH) begin
                n_flushes++;
                for (int i = 0; i < SLOTS; i++) begin
                    if (dirty[i] && flushed < MAX_RESULTS) begin
                        awaited.push_back(make_result(i, 1'b0, 1'b1, tags[i], 1'b0));
                        flushed++;
                        vld[i]        = 1'b0;
                        referenced[i] = 1'b0;
                        modified[i]   = 1'b0;
                        dirty[i]      = 1'b0;
                    end
                end
                if (flushed == 0)
                    awaited.push_back(make_result(0, 1'b0, 1'b0, '0, 1'b1));
                else
                    awaited[awaited.size() - 1].last = 1'b1;
                return;
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && vld[i] && tags[i] == addr) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                n_hits++;
                referenced[slot] = 1'b1;
                if (action == ACT_WRITE) begin
                    modified[slot] = 1'b1;
                    dirty[slot]    = 1'b1;
                end
                awaited.push_back(make_result(slot, 1'b1, 1'b0, '0, 1'b1));
                return;
            end
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!vld[i])
                    slot = i;
            if (slot >= SLOTS) begin
                n_sweeps++;
                slot = choose_victim();
                if (dirty[slot]) begin
                    wb  = 1'b1;
                    old = tags[slot];
                    n_write_backs++;
                end
            end
            hand             = slot;
            tags[slot]       = addr;
            vld[slot]        = 1'b1;
            referenced[slot] = 1'b1;
            modified[slot]   = (action == ACT_WRITE);
            dirty[slot]      = (action == ACT_WRITE);
            awaited.push_back(make_result(slot, 1'b0, wb, old, 1'b1));
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_results++;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: slot %0d hit %0b write_back %0b old_page %h",
                       got.slot, got.hit, got.write_back, got.old_page);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %0b, got %0b", want.hit, got.hit);
                errors++;
            end
            if (got.write_back !== want.write_back) begin
                $error("write_back: expected %0b, got %0b", want.write_back, got.write_back);
                errors++;
            end
            if (got.old_page !== want.old_page) begin
                $error("old_page: expected %h, got %h", want.old_page, got.old_page);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] page_addr
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [3:0] slot, [35:4] old_page, [39:36] zero
    logic [1:0]  m_axis_tuser;          // [0] hit, [1] write_back
    logic        m_axis_tlast;

    page_tag_scoreboard tags_sb = new();

    // Addresses the random requests mostly draw from: more pages than slots, so
    // the buffer keeps hitting, filling up and evicting.
    t_addr page_pool[24];

    bit          hold_off_go = 1'b0;
    bit          hold_off_done = 1'b0;
    int          hold_left = 0;
    int          ready_mode = 0;
    int          ready_mode_left = 0;
    int          stall_cycles = 0;
    int          ignored_requests = 0;

    page_buffer_clock_replacement_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request and hold it until the block takes the transaction.
    // Leave tvalid high afterwards; the next request or a pause decides its level.
    task automatic send_request(input logic [ACT_W-1:0] action, input t_addr addr);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        tags_sb.note_request(action, addr);
        if (action == ACT_UNUSED)
            ignored_requests++;
    endtask

    // Drop tvalid for a number of cycles and scramble the idle bus.
    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom;
        s_axis_tuser  <= 2'($urandom_range(0, 3));
        repeat (cycles - 1)
            @(negedge i_clk);
    endtask

    // Receiver: one long hold-off once the main flow asks for it, otherwise one of
    // four stall patterns, picked anew at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left     = HOLD_OFF_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (ready_mode_left == 0) begin
                ready_mode      = $urandom_range(0, 3);
                ready_mode_left = $urandom_range(20, 80);
            end else begin
                ready_mode_left--;
            end
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (ready_mode_left % 8) < 5;
            endcase
        end
    end

    // Check each result transaction at the edge that moves it.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.slot       = m_axis_tdata[3:0];
            got.old_page   = m_axis_tdata[35:4];
            got.hit        = m_axis_tuser[0];
            got.write_back = m_axis_tuser[1];
            got.last       = m_axis_tlast;
            tags_sb.check_result(got);
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles == STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int          sent;
        int          burst;
        int          pick;
        logic [1:0]  action;
        t_addr       addr;

        for (int i = 0; i < 24; i++)
            page_pool[i] = $urandom;
        page_pool[0] = 32'h0000_0000;
        page_pool[1] = 32'hFFFF_FFFF;

        repeat (7)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Start with a flush on an empty buffer (single empty result)
        // and an ignored action code.
        send_request(ACT_FLUSH, 32'h1234_5678);
        send_request(ACT_UNUSED, 32'hDEAD_BEEF);
        // Fill with the extreme addresses, then hit one by read and the other by write.
        send_request(ACT_READ, 32'h0000_0000);
        send_request(ACT_WRITE, 32'hFFFF_FFFF);
        send_request(ACT_READ, 32'hFFFF_FFFF);
        send_request(ACT_WRITE, 32'h0000_0000);
        // Flush both dirty slots: two write-backs, the second one marked last.
        send_request(ACT_FLUSH, 32'h0);
        // Fill every slot, alternating write and read fills, so the buffer is full.
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 0)
                addr = 32'hAAAA_AAAA;
            else if (i == 1)
                addr = 32'h5555_5555;
            else
                addr = 32'hA5A5_0000 + i;
            send_request((i % 2 == 0) ? ACT_WRITE : ACT_READ, addr);
        end
        // Misses on a full buffer: sweeps strip use bits, then evict clean pages.
        send_request(ACT_WRITE, 32'h8000_0000);
        send_request(ACT_READ, 32'h7FFF_FFFF);
        send_request(ACT_WRITE, 32'h0F0F_0F0F);
        send_request(ACT_READ, 32'hF0F0_F0F0);
        pause_sender($urandom_range(1, 6));

        // Random part: bursts of requests over a small page pool with some fresh
        // addresses mixed in, and gaps of random length between most bursts.
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 10);
            for (int b = 0; b < burst && sent < RANDOM_REQUESTS; b++) begin
                pick = $urandom_range(0, 99);
                if (pick < 46)
                    action = ACT_READ;
                else if (pick < 86)
                    action = ACT_WRITE;
                else if (pick < 95)
                    action = ACT_FLUSH;
                else
                    action = ACT_UNUSED;
                addr = ($urandom_range(0, 4) == 0) ? t_addr'($urandom)
                                                   : page_pool[$urandom_range(0, 23)];
                send_request(action, addr);
                if (action != ACT_UNUSED)
                    sent++;
                // Hold the receiver off once while requests keep coming.
                if (sent == 60)
                    hold_off_go = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (tags_sb.awaited.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);

        $display("tb: %0d requests (%0d ignored), %0d results checked", tags_sb.n_requests,
                 ignored_requests, tags_sb.n_results);
        $display("tb: %0d hits, %0d victim sweeps, %0d dirty evictions, %0d flushes",
                 tags_sb.n_hits, tags_sb.n_sweeps, tags_sb.n_write_backs, tags_sb.n_flushes);
        if (tags_sb.errors == 0 && tags_sb.awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pbcr_pkg.sv
rtl/pbcr_tag_ram.sv
rtl/pbcr_ctrl.sv
rtl/page_buffer_clock_replacement_core.sv
tb/sv/page_buffer_clock_replacement_core_test.sv
